// ----- hw/rtl/json_string_unescape_utf8_core_macros.svh -----
// Assertion macros used by the checks in the top level of this block.
`ifndef JSON_STRING_UNESCAPE_UTF8_CORE_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define JSU_ASSERT_IMPL(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define JSU_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ----- hw/rtl/jsu_pkg.sv -----
package jsu_pkg;

   // Width and reset value of the capacity register.
   localparam int CAP_W       = 13;
   localparam int RESET_CAP   = 4096;
   localparam int DEFAULT_MAX_CAPACITY = 4096;

   // Number of runs the queue between front and back can hold.
   localparam int QUEUE_DEPTH = 4;

   // Status codes of the result that ends a string.
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_ESC   = 3'd1;
   localparam logic [2:0] ST_BAD_HEX   = 3'd2;
   localparam logic [2:0] ST_BAD_SUR   = 3'd3;
   localparam logic [2:0] ST_CTRL      = 3'd4;
   localparam logic [2:0] ST_FULL      = 3'd5;
   localparam logic [2:0] ST_TRUNC     = 3'd6;

   typedef struct packed {
      logic [7:0] ch;
      logic       has_char;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_byte;
      logic       finished;
      logic [2:0] status;
      logic       last_of_run;
   } rsp_type;

   // All results caused by one input item: up to four data bytes, then an
   // optional status result.
   typedef struct packed {
      logic [3:0][7:0] data;
      logic [2:0]      nbytes;
      logic            has_status;
      logic [2:0]      status;
   } run_type;

endpackage

// ----- hw/rtl/jsu_front.sv -----
module jsu_front import jsu_pkg::*; #(
   parameter int MAX_CAPACITY = DEFAULT_MAX_CAPACITY,
   localparam int EFF_MAX = (MAX_CAPACITY < 8191) ? MAX_CAPACITY : 8191,
   localparam int CNT_W = $clog2(EFF_MAX + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_payload,
   input  logic [CNT_W-1:0]  eff_cap,
   input  logic              queue_full,
   output logic              run_push,
   output run_type           run_data
);

   typedef enum logic [5:0] {
      PH_PLAIN   = 6'b000001,
      PH_ESC     = 6'b000010,
      PH_HEX1    = 6'b000100,
      PH_NEED_BS = 6'b001000,
      PH_NEED_U  = 6'b010000,
      PH_HEX2    = 6'b100000
   } phase_type;

   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_U         = 8'h75;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] LEAD2        = 8'hC0;
   localparam logic [7:0] LEAD3        = 8'hE0;
   localparam logic [7:0] LEAD4        = 8'hF0;
   localparam logic [7:0] CONT         = 8'h80;
   localparam logic [15:0] HI_FIRST    = 16'hD800;
   localparam logic [15:0] HI_LAST     = 16'hDBFF;
   localparam logic [15:0] LO_FIRST    = 16'hDC00;
   localparam logic [15:0] LO_LAST     = 16'hDFFF;
   localparam logic [20:0] PLANE1      = 21'h10000;
   localparam logic [20:0] TWO_BYTE    = 21'h00080;
   localparam logic [20:0] THREE_BYTE  = 21'h00800;

   phase_type         phase_ff, phase_in;
   logic [1:0]        digit_ff, digit_in;
   logic [15:0]       first_ff, first_in;
   logic [15:0]       second_ff, second_in;
   logic [CNT_W-1:0]  written_ff, written_in;
   logic              rejected_ff, rejected_in;

   logic              accept;
   logic              nib_ok;
   logic [3:0]        nib;
   logic [15:0]       first_word;
   logic [15:0]       second_word;
   logic              emit_raw;
   logic              emit_cp;
   logic [20:0]       cp;
   logic [2:0]        err;
   logic [2:0]        nbytes;
   logic [3:0][7:0]   bytes;
   logic [CNT_W:0]    need;
   run_type           run;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      nib_ok = 1'b1;
      nib    = req_payload.ch[3:0];
      case (req_payload.ch) inside
         [8'h30:8'h39]: nib = req_payload.ch[3:0];
         [8'h41:8'h46],
         [8'h61:8'h66]: nib = req_payload.ch[3:0] + 4'd9;
         default: begin
            nib_ok = 1'b0;
         end
      endcase
   end

   assign first_word  = {first_ff[11:0], nib};
   assign second_word = {second_ff[11:0], nib};

   always_comb begin
      phase_in    = phase_ff;
      digit_in    = digit_ff;
      first_in    = first_ff;
      second_in   = second_ff;
      written_in  = written_ff;
      rejected_in = rejected_ff;
      err         = ST_OK;
      emit_raw    = 1'b0;
      emit_cp     = 1'b0;
      cp          = '0;
      nbytes      = 3'd0;
      bytes       = '0;
      need        = '0;
      run         = '0;

      if (req_payload.has_char) begin
         case (phase_ff)
            PH_ESC: begin
               if (req_payload.ch == CH_U) begin
                  phase_in = PH_HEX1;
                  digit_in = 2'd0;
                  first_in = '0;
               end else if (req_payload.ch inside {CH_SLASH, CH_BACKSLASH, CH_QUOTE}) begin
                  phase_in = PH_PLAIN;
                  emit_raw = 1'b1;
               end else begin
                  err = ST_BAD_ESC;
               end
            end
            PH_HEX1: begin
               if (!nib_ok) begin
                  err = ST_BAD_HEX;
               end else begin
                  first_in = first_word;
                  if (digit_ff != 2'd3) begin
                     digit_in = digit_ff + 2'd1;
                  end else begin
                     digit_in = 2'd0;
                     if (first_word inside {[HI_FIRST:HI_LAST]}) begin
                        phase_in = PH_NEED_BS;
                     end else if (first_word inside {[LO_FIRST:LO_LAST]}) begin
                        err = ST_BAD_SUR;
                     end else begin
                        phase_in = PH_PLAIN;
                        emit_cp  = 1'b1;
                        cp       = {5'd0, first_word};
                     end
                  end
               end
            end
            PH_NEED_BS: begin
               if (req_payload.ch != CH_BACKSLASH) begin
                  err = ST_BAD_SUR;
               end else begin
                  phase_in = PH_NEED_U;
               end
            end
            PH_NEED_U: begin
               if (req_payload.ch != CH_U) begin
                  err = ST_BAD_SUR;
               end else begin
                  phase_in  = PH_HEX2;
                  digit_in  = 2'd0;
                  second_in = '0;
               end
            end
            PH_HEX2: begin
               if (!nib_ok) begin
                  err = ST_BAD_HEX;
               end else begin
                  second_in = second_word;
                  if (digit_ff != 2'd3) begin
                     digit_in = digit_ff + 2'd1;
                  end else begin
                     digit_in = 2'd0;
                     if (!(second_word inside {[LO_FIRST:LO_LAST]})) begin
                        err = ST_BAD_SUR;
                     end else begin
                        // The high unit is known to lie in D800..DBFF and the low one in
                        // DC00..DFFF, so the offsets are just their low ten bits.
                        phase_in = PH_PLAIN;
                        emit_cp  = 1'b1;
                        cp       = PLANE1 + {1'b0, first_ff[9:0], second_word[9:0]};
                     end
                  end
               end
            end
            default: begin
               // Plain text.
               phase_in = PH_PLAIN;
               if (req_payload.ch == CH_BACKSLASH) begin
                  phase_in = PH_ESC;
               end else if (req_payload.ch < CH_SPACE) begin
                  err = ST_CTRL;
               end else begin
                  emit_raw = 1'b1;
               end
            end
         endcase
      end

      // Encode the byte or code point.
      if (emit_raw) begin
         nbytes   = 3'd1;
         bytes[0] = req_payload.ch;
      end else if (emit_cp) begin
         if (cp == '0) begin
            err = ST_CTRL;
         end else if (cp < TWO_BYTE) begin
            nbytes   = 3'd1;
            bytes[0] = cp[7:0];
         end else if (cp < THREE_BYTE) begin
            nbytes   = 3'd2;
            bytes[0] = LEAD2 | {3'd0, cp[10:6]};
            bytes[1] = CONT | {2'd0, cp[5:0]};
         end else if (cp < PLANE1) begin
            nbytes   = 3'd3;
            bytes[0] = LEAD3 | {4'd0, cp[15:12]};
            bytes[1] = CONT | {2'd0, cp[11:6]};
            bytes[2] = CONT | {2'd0, cp[5:0]};
         end else begin
            nbytes   = 3'd4;
            bytes[0] = LEAD4 | {5'd0, cp[20:18]};
            bytes[1] = CONT | {2'd0, cp[17:12]};
            bytes[2] = CONT | {2'd0, cp[11:6]};
            bytes[3] = CONT | {2'd0, cp[5:0]};
         end
      end

      // All bytes of a code point go out, or none do.
      need = {1'b0, written_ff} + (CNT_W+1)'(nbytes);
      if (nbytes != 3'd0) begin
         if (need >= {1'b0, eff_cap}) begin
            err    = ST_FULL;
            nbytes = 3'd0;
         end else begin
            written_in = need[CNT_W-1:0];
         end
      end

      run.data   = bytes;
      run.nbytes = nbytes;

      if (err != ST_OK) begin
         run.has_status = 1'b1;
         run.status     = err;
      end else if (req_payload.last) begin
         run.has_status = 1'b1;
         if (phase_in != PH_PLAIN) begin
            run.status = ST_TRUNC;
         end else if (eff_cap == '0) begin
            run.status = ST_FULL;
         end else begin
            run.status = ST_OK;
         end
      end

      if (run.has_status) begin
         phase_in    = PH_PLAIN;
         digit_in    = 2'd0;
         first_in    = '0;
         second_in   = '0;
         written_in  = '0;
         rejected_in = (err != ST_OK) && !req_payload.last;
      end

      // After an error everything up to the last item is dropped.
      if (rejected_ff) begin
         run         = '0;
         phase_in    = phase_ff;
         digit_in    = digit_ff;
         first_in    = first_ff;
         second_in   = second_ff;
         written_in  = written_ff;
         rejected_in = !req_payload.last;
      end
   end

   assign run_push = accept && (run.nbytes != 3'd0 || run.has_status);
   assign run_data = run;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_PLAIN;
         digit_ff    <= 2'd0;
         first_ff    <= '0;
         second_ff   <= '0;
         written_ff  <= '0;
         rejected_ff <= 1'b0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         digit_ff    <= digit_in;
         first_ff    <= first_in;
         second_ff   <= second_in;
         written_ff  <= written_in;
         rejected_ff <= rejected_in;
      end
   end

endmodule

// ----- hw/rtl/jsu_queue.sv -----
module jsu_queue import jsu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  run_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output run_type head
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   run_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hw/rtl/jsu_back.sv -----
module jsu_back import jsu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    head_valid,
   input  run_type head,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic [2:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_payload_ff, rsp_payload_in;
   logic       load;
   logic [2:0] total;
   logic       final_one;

   assign load      = !rsp_valid_ff || !rsp_stall;
   assign total     = head.nbytes + {2'd0, head.has_status};
   assign final_one = (idx_ff == total - 3'd1);
   assign pop       = load && head_valid && final_one;

   always_comb begin
      idx_in         = idx_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (load) begin
         rsp_valid_in = head_valid;
         if (head_valid) begin
            if (idx_ff < head.nbytes) begin
               rsp_payload_in.out_byte = head.data[idx_ff[1:0]];
               rsp_payload_in.is_byte  = 1'b1;
               rsp_payload_in.finished = 1'b0;
               rsp_payload_in.status   = ST_OK;
            end else begin
               rsp_payload_in.out_byte = 8'd0;
               rsp_payload_in.is_byte  = 1'b0;
               rsp_payload_in.finished = 1'b1;
               rsp_payload_in.status   = head.status;
            end
            rsp_payload_in.last_of_run = final_one;
            idx_in = final_one ? 3'd0 : idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ----- hw/rtl/json_string_unescape_utf8_core.sv -----
// Channel   Direction  Handshake               Contents
// req_*     in         req_valid / req_stall   ch, has_char, last (one body byte)
// rsp_*     out        rsp_valid / rsp_stall   out_byte, is_byte, finished, status, last_of_run
// csr_*     in         csr_wr_en               capacity, 13 bits, no read-back
//
// Flow: an item that causes at most one result is taken every cycle while the
// run queue is not full; an item that causes several results holds the output
// register while the back end sends them, one per cycle when rsp_stall is low.
// The four-entry run queue absorbs such bursts; an item's results pass through it
// and then the registered output stage. Reset is synchronous; there is no clearing pass.
// req_stall rises only when the run queue is full; rsp_stall never blocks
// the front directly, only through the queue filling up.

`include "json_string_unescape_utf8_core_macros.svh"

module json_string_unescape_utf8_core import jsu_pkg::*; #(
   parameter int MAX_CAPACITY = DEFAULT_MAX_CAPACITY
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_payload,
   input  logic             csr_wr_en,
   input  logic [CAP_W-1:0] csr_wr_data
);

   // The byte counter never has to go past the smaller of the capacity field's
   // range and the configured maximum, so its width follows from that.
   localparam int EFF_MAX = (MAX_CAPACITY < 8191) ? MAX_CAPACITY : 8191;
   localparam int CNT_W   = $clog2(EFF_MAX + 1);
   localparam int RESET_EFF = (RESET_CAP > EFF_MAX) ? EFF_MAX : RESET_CAP;

   // The register holds the clamped capacity, so the front end compares against it
   // directly. The user must write it only while the block is idle; it is not enforced.
   logic [CNT_W-1:0] eff_cap_ff, eff_cap_in;

   logic    queue_full;
   logic    run_push;
   run_type run_data;
   logic    head_valid;
   run_type head;
   logic    pop;

   assign eff_cap_in = (int'(csr_wr_data) > EFF_MAX) ? CNT_W'(EFF_MAX)
                                                      : CNT_W'(csr_wr_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_cap_ff <= CNT_W'(RESET_EFF);
      end else if (csr_wr_en) begin
         eff_cap_ff <= eff_cap_in;
      end
   end

   // The front end decodes escapes and surrogate pairs, checks capacity, and
   // packs every result of one item into a single run.
   jsu_front #(
      .MAX_CAPACITY (MAX_CAPACITY)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .eff_cap     (eff_cap_ff),
      .queue_full  (queue_full),
      .run_push    (run_push),
      .run_data    (run_data)
   );

   // Runs wait here so that a slow consumer does not stall decoding at once.
   jsu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (run_push),
      .push_data  (run_data),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   // The back end unpacks each run into results, one per cycle while rsp_stall is
   // low, into a registered output stage.
   jsu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // A run is never written into a full queue.
   `JSU_ASSERT_IMPL(a_no_overflow, clock, reset, run_push, !queue_full, "run pushed into full queue")

   // Every status result ends the string and closes the run of its item.
   `JSU_ASSERT_IMPL(a_status_ends, clock, reset, rsp_valid && !rsp_payload.is_byte, rsp_payload.finished && rsp_payload.last_of_run, "status result not final")

   // Data bytes carry no status and never end a string.
   `JSU_ASSERT_IMPL(a_byte_clean, clock, reset, rsp_valid && rsp_payload.is_byte, !rsp_payload.finished && rsp_payload.status == ST_OK, "data byte with status")

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
   import jsu_pkg::*;

   // Body bytes that the escape grammar cares about.
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_U      = 8'h75;

   // Clock period is 20 ns, so this is a few milliseconds of simulated time.
   // The slowest legal run, with five results per item and long stalls, stays
   // well under a tenth of this.
   localparam int CYCLE_LIMIT   = 200000;
   // Idle cycles allowed before a capacity write. The run queue holds four runs;
   // the wait covers an item that made no result.
   localparam int SETTLE_CYCLES = 20;

   // Where the unescaper is inside the current string.
   typedef enum logic [2:0] {
      PH_TEXT,
      PH_ESCAPE,
      PH_FIRST_HEX,
      PH_NEED_BSLASH,
      PH_NEED_U,
      PH_SECOND_HEX
   } scan_phase_type;

   // The scoreboard keeps its own copy of the parser state and of the capacity
   // register. Each accepted body item is run through it and the results it
   // would cause are queued. Each result from the block is checked against the
   // oldest queued one.
   class unescape_tracker;
      rsp_type          pending_output[$];
      rsp_type          item_output[$];
      logic [CAP_W-1:0] capacity;
      scan_phase_type   phase;
      int unsigned      digit_count;
      logic [15:0]      first_unit;
      logic [15:0]      second_unit;
      int unsigned      bytes_written;
      bit               rejected;
      int               mismatches;
      int               items_noted;
      int               live_items;
      int               results_checked;
      int               strings_ended;
      int               error_endings;

      function new();
         capacity = RESET_CAP;
         clear_string();
      endfunction

      function void clear_string();
         phase = PH_TEXT;
         digit_count = 0;
         first_unit = '0;
         second_unit = '0;
         bytes_written = 0;
         rejected = 1'b0;
      endfunction

      // Values above the build-time maximum behave as the maximum.
      function int unsigned usable_capacity();
         if (capacity > DEFAULT_MAX_CAPACITY) return DEFAULT_MAX_CAPACITY;
         return capacity;
      endfunction

      function int hex_value(logic [7:0] c);
         if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
         if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
         if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
         return -1;
      endfunction

      // A code point goes out whole or not at all; one slot stays free for
      // the terminator.
      function logic [2:0] emit_bytes(logic [7:0] seq [4], int unsigned count);
         rsp_type r;
         if (bytes_written + count >= usable_capacity()) return ST_FULL;
         for (int i = 0; i < count; i++) begin
            r = '0;
            r.out_byte = seq[i];
            r.is_byte = 1'b1;
            item_output.push_back(r);
         end
         bytes_written += count;
         return ST_OK;
      endfunction

      function logic [2:0] encode_point(int unsigned cp);
         logic [7:0] seq [4];
         if (cp == 0) return ST_CTRL;
         if (cp < 'h80) begin
            seq[0] = 8'(cp);
            return emit_bytes(seq, 1);
         end
         if (cp < 'h800) begin
            seq[0] = 8'('hC0 | (cp >> 6));
            seq[1] = 8'('h80 | (cp & 63));
            return emit_bytes(seq, 2);
         end
         if (cp < 'h10000) begin
            seq[0] = 8'('hE0 | (cp >> 12));
            seq[1] = 8'('h80 | ((cp >> 6) & 63));
            seq[2] = 8'('h80 | (cp & 63));
            return emit_bytes(seq, 3);
         end
         seq[0] = 8'('hF0 | (cp >> 18));
         seq[1] = 8'('h80 | ((cp >> 12) & 63));
         seq[2] = 8'('h80 | ((cp >> 6) & 63));
         seq[3] = 8'('h80 | (cp & 63));
         return emit_bytes(seq, 4);
      endfunction

      function logic [2:0] consume_byte(logic [7:0] ch);
         int         nib;
         logic [7:0] seq [4];
         seq[0] = ch;
         case (phase)
            PH_ESCAPE: begin
               if (ch == CH_U) begin
                  phase = PH_FIRST_HEX;
                  digit_count = 0;
                  first_unit = '0;
                  return ST_OK;
               end
               if (ch != CH_SLASH && ch != CH_BSLASH && ch != CH_QUOTE) return ST_BAD_ESC;
               phase = PH_TEXT;
               return emit_bytes(seq, 1);
            end
            PH_FIRST_HEX: begin
               nib = hex_value(ch);
               if (nib < 0) return ST_BAD_HEX;
               first_unit = {first_unit[11:0], 4'(nib)};
               if (digit_count < 3) begin
                  digit_count++;
                  return ST_OK;
               end
               digit_count = 0;
               if (first_unit >= 16'hD800 && first_unit <= 16'hDBFF) begin
                  phase = PH_NEED_BSLASH;
                  return ST_OK;
               end
               if (first_unit >= 16'hDC00 && first_unit <= 16'hDFFF) return ST_BAD_SUR;
               phase = PH_TEXT;
               return encode_point(32'(first_unit));
            end
            PH_NEED_BSLASH: begin
               if (ch != CH_BSLASH) return ST_BAD_SUR;
               phase = PH_NEED_U;
               return ST_OK;
            end
            PH_NEED_U: begin
               if (ch != CH_U) return ST_BAD_SUR;
               phase = PH_SECOND_HEX;
               digit_count = 0;
               second_unit = '0;
               return ST_OK;
            end
            PH_SECOND_HEX: begin
               nib = hex_value(ch);
               if (nib < 0) return ST_BAD_HEX;
               second_unit = {second_unit[11:0], 4'(nib)};
               if (digit_count < 3) begin
                  digit_count++;
                  return ST_OK;
               end
               digit_count = 0;
               if (second_unit < 16'hDC00 || second_unit > 16'hDFFF) return ST_BAD_SUR;
               phase = PH_TEXT;
               return encode_point(32'h10000 + ((32'(first_unit) - 32'hD800) << 10)
                                   + (32'(second_unit) - 32'hDC00));
            end
            default: begin
               phase = PH_TEXT;
               if (ch == CH_BSLASH) begin
                  phase = PH_ESCAPE;
                  return ST_OK;
               end
               if (ch < 8'd32) return ST_CTRL;
               return emit_bytes(seq, 1);
            end
         endcase
      endfunction

      function void note_body_item(req_type item);
         logic [2:0] err;
         rsp_type    r;
         item_output.delete();
         items_noted++;
         err = ST_OK;
         // After an error everything up to the end of the string is dropped.
         if (rejected) begin
            if (item.last) clear_string();
            return;
         end
         if (item.has_char || item.last) live_items++;
         if (item.has_char) err = consume_byte(item.ch);
         r = '0;
         r.finished = 1'b1;
         if (err != ST_OK) begin
            r.status = err;
            item_output.push_back(r);
            clear_string();
            if (!item.last) rejected = 1'b1;
            error_endings++;
            strings_ended++;
         end else if (item.last) begin
            if (phase != PH_TEXT) r.status = ST_TRUNC;
            else if (usable_capacity() == 0) r.status = ST_FULL;
            else r.status = ST_OK;
            item_output.push_back(r);
            clear_string();
            if (r.status != ST_OK) error_endings++;
            strings_ended++;
         end
         if (item_output.size() > 0) item_output[item_output.size() - 1].last_of_run = 1'b1;
         foreach (item_output[i]) pending_output.push_back(item_output[i]);
      endfunction

      task flag_mismatch(string msg);
         mismatches++;
         $display("testbench: mismatch: %s", msg);
      endtask

      task check_output(rsp_type got);
         rsp_type want;
         results_checked++;
         if (pending_output.size() == 0) begin
            flag_mismatch($sformatf("result %0d arrived with none expected (byte %02h data %b)",
                                    results_checked, got.out_byte, got.is_byte));
            return;
         end
         want = pending_output.pop_front();
         if (got.out_byte !== want.out_byte || got.is_byte !== want.is_byte
             || got.finished !== want.finished || got.status !== want.status
             || got.last_of_run !== want.last_of_run) begin
            flag_mismatch($sformatf({"result %0d: byte %02h data %b end %b status %0d runend %b,",
                                     " expected %02h %b %b %0d %b"},
                                    results_checked, got.out_byte, got.is_byte, got.finished,
                                    got.status, got.last_of_run, want.out_byte, want.is_byte,
                                    want.finished, want.status, want.last_of_run));
         end
      endtask
   endclass

   // Every input of the block starts at a known value, with reset held.
   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_payload = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_payload;
   logic             csr_wr_en = 1'b0;
   logic [CAP_W-1:0] csr_wr_data = '0;

   unescape_tracker  sb;
   req_type          string_items[$];
   int               send_idle_pct = 0;
   int               recv_stall_pct = 0;
   int               cycle_count = 0;

   json_string_unescape_utf8_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Both channels are sampled at the rising edge, before any of this edge's
   // nonblocking updates land, so the testbench sees exactly what the block
   // sees. The item side is noted first; since results are registered, a result
   // can never belong to an item accepted at the same edge anyway.
   // The receiver's stall is drawn fresh each cycle and never looks at valid.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_body_item(req_payload);
         if (rsp_valid && !rsp_stall) sb.check_output(rsp_payload);
      end
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // A hang anywhere (a lost result, a stall that never drops) ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench: timed out with %0d results outstanding",
                  sb.pending_output.size());
         $display("testbench: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Building strings. Each helper appends items to string_items; nothing is
   // driven until send_string() walks the list.
   // ---------------------------------------------------------------------

   function automatic void put_byte(logic [7:0] c);
      req_type it;
      it.ch = c;
      it.has_char = 1'b1;
      it.last = 1'b0;
      string_items.push_back(it);
   endfunction

   // An item with no character. With last set it closes the string; without,
   // the block must ignore it.
   function automatic void put_no_char(bit is_last);
      req_type it;
      it.ch = 8'($urandom);
      it.has_char = 1'b0;
      it.last = is_last;
      string_items.push_back(it);
   endfunction

   function automatic void mark_last();
      string_items[string_items.size() - 1].last = 1'b1;
   endfunction

   // A string ends either on its final byte or on a separate empty item.
   function automatic void put_end();
      if (string_items.size() > 0 && $urandom_range(1)) mark_last();
      else put_no_char(1'b1);
   endfunction

   // Hex digits in upper or lower case at random.
   function automatic logic [7:0] hex_char(logic [3:0] nib);
      if (nib < 4'd10) return 8'h30 + 8'(nib);
      if ($urandom_range(1)) return 8'h41 + 8'(nib) - 8'd10;
      return 8'h61 + 8'(nib) - 8'd10;
   endfunction

   function automatic void put_unit(logic [15:0] unit);
      put_byte(CH_BSLASH);
      put_byte(CH_U);
      for (int i = 3; i >= 0; i--) put_byte(hex_char(unit[i*4 +: 4]));
   endfunction

   function automatic logic [15:0] high_unit();
      // Lean on the ends of the range now and then.
      case ($urandom_range(3))
         0: return 16'hD800;
         1: return 16'hDBFF;
         default: return 16'($urandom_range('hD800, 'hDBFF));
      endcase
   endfunction

   function automatic logic [15:0] low_unit();
      case ($urandom_range(3))
         0: return 16'hDC00;
         1: return 16'hDFFF;
         default: return 16'($urandom_range('hDC00, 'hDFFF));
      endcase
   endfunction

   // A byte that can never be a hex digit; includes both neighbors of each
   // digit range.
   function automatic logic [7:0] non_hex();
      logic [7:0] picks [9];
      picks = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67, 8'h00, 8'hFF, 8'h20};
      return picks[$urandom_range(8)];
   endfunction

   // One well-formed piece of string content.
   function automatic void put_segment();
      logic [7:0]  c;
      int unsigned v;
      case ($urandom_range(9))
         4: begin
            put_byte(CH_BSLASH);
            case ($urandom_range(2))
               0: put_byte(CH_SLASH);
               1: put_byte(CH_BSLASH);
               default: put_byte(CH_QUOTE);
            endcase
         end
         5: put_unit(16'($urandom_range(1, 'h7F)));
         6: put_unit(16'($urandom_range('h80, 'h7FF)));
         7: begin
            // Three-byte range with the surrogate block skipped.
            v = $urandom_range('h800, 'hF7FF);
            if (v >= 'hD800) v += 'h800;
            put_unit(16'(v));
         end
         8: begin
            put_unit(high_unit());
            put_unit(low_unit());
         end
         9: put_no_char(1'b0);
         default: begin
            c = 8'($urandom_range(32, 255));
            if (c == CH_BSLASH) c = 8'h7E;
            put_byte(c);
         end
      endcase
   endfunction

   function automatic void build_good_string();
      repeat ($urandom_range(0, 6)) put_segment();
      put_end();
   endfunction

   // Some good content, then one fault, then up to three bytes that must be
   // swallowed (none after a cut escape), then the end of the string.
   function automatic void build_broken_string();
      logic [7:0]  c;
      logic [15:0] u;
      int          keep;
      bit          truncated;
      truncated = 1'b0;
      repeat ($urandom_range(0, 3)) put_segment();
      case ($urandom_range(9))
         0: put_byte(8'($urandom_range(0, 31)));
         1: begin
            put_byte(CH_BSLASH);
            c = 8'($urandom);
            if (c == CH_U || c == CH_SLASH || c == CH_BSLASH || c == CH_QUOTE) c = 8'h6E;
            put_byte(c);
         end
         2: begin
            // Bad digit even when the escape would also be cut short.
            put_byte(CH_BSLASH);
            put_byte(CH_U);
            repeat ($urandom_range(0, 3)) put_byte(hex_char(4'($urandom)));
            put_byte(non_hex());
         end
         3: put_unit(low_unit());
         4: begin
            put_unit(high_unit());
            c = 8'($urandom);
            if (c == CH_BSLASH) c = 8'h41;
            put_byte(c);
         end
         5: begin
            put_unit(high_unit());
            put_byte(CH_BSLASH);
            c = 8'($urandom);
            if (c == CH_U) c = CH_BSLASH;
            put_byte(c);
         end
         6: begin
            u = 16'($urandom);
            if (u >= 16'hDC00 && u <= 16'hDFFF) u ^= 16'h2000;
            put_unit(high_unit());
            put_unit(u);
         end
         7: put_unit(16'h0000);
         8: begin
            // Cut a surrogate pair escape somewhere inside its twelve bytes.
            keep = $urandom_range(1, 11);
            put_unit(high_unit());
            put_unit(low_unit());
            repeat (12 - keep) void'(string_items.pop_back());
            truncated = 1'b1;
         end
         default: begin
            put_unit(high_unit());
            put_byte(CH_BSLASH);
            put_byte(CH_U);
            repeat ($urandom_range(0, 3)) put_byte(hex_char(4'($urandom)));
            put_byte(non_hex());
         end
      endcase
      if (!truncated) repeat ($urandom_range(0, 3)) put_byte(8'($urandom));
      put_end();
   endfunction

   // ---------------------------------------------------------------------
   // Driving.
   // ---------------------------------------------------------------------

   // The gap decision is made before valid rises and never looks at stall.
   // Valid stays high from one accepted item to the next when there is no
   // gap, so it gets one assignment per edge.
   task automatic send_item(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_string();
      foreach (string_items[i]) send_item(string_items[i]);
      string_items.delete();
   endtask

   // Wait until the last accepted item has surely been noted, then until
   // every expected result is in, then give an item that made no result
   // time to leave the pipeline.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_output.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.capacity = value;
   endtask

   // One phase: a capacity setting, a flow pattern, and strings until enough
   // items have reached live parsing. Three strings in four are well formed.
   task automatic run_phase(input logic [CAP_W-1:0] cap, input int send_pct,
                            input int stall_pct, input int target);
      int stop_at;
      write_capacity(cap);
      send_idle_pct = send_pct;
      recv_stall_pct = stall_pct;
      stop_at = sb.live_items + target;
      while (sb.live_items < stop_at) begin
         if ($urandom_range(99) < 75) build_good_string();
         else build_broken_string();
         send_string();
      end
      wait_for_drain();
   endtask

   initial begin
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed strings at the reset capacity, with no idling.
      // Lowest and highest pass-through bytes, then two short escapes.
      put_byte(8'h20);
      put_byte(8'hFF);
      put_byte(CH_BSLASH);
      put_byte(CH_SLASH);
      put_byte(CH_BSLASH);
      put_byte(CH_QUOTE);
      mark_last();
      // A surrogate pair ending on the last item: four bytes and the status
      // all come from that one item.
      put_unit(16'hD83D);
      put_unit(16'hDE00);
      mark_last();
      // Empty string.
      put_no_char(1'b1);
      // Raw NUL mid-string, then a byte that must be swallowed.
      put_byte(8'h00);
      put_byte(8'h78);
      put_no_char(1'b1);
      // String that stops right after a backslash.
      put_byte(CH_BSLASH);
      mark_last();
      // Bad digit that is also the last byte: the digit error wins.
      put_byte(CH_BSLASH);
      put_byte(CH_U);
      put_byte(8'h67);
      mark_last();
      send_string();
      wait_for_drain();

      // Random phases. Capacity runs from zero and one (nothing fits) through
      // tiny buffers that fill mid-string, to the maximum and a value above it.
      run_phase(13'd4096, 0, 0, 70);
      run_phase(13'd8191, 65, 0, 70);
      run_phase(13'd6, 0, 65, 70);
      run_phase(13'd1, 15, 15, 40);
      run_phase(13'd0, 0, 0, 20);
      run_phase(13'd2, 15, 15, 30);
      run_phase(13'd300, 0, 0, 30);

      $display("testbench: %0d items taken, %0d reached the parser, %0d results compared",
               sb.items_noted, sb.live_items, sb.results_checked);
      $display("testbench: %0d strings closed, %0d with an error status, capacity 0 to 8191",
               sb.strings_ended, sb.error_endings);
      if (sb.mismatches == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/jsu_pkg.sv
hw/rtl/jsu_front.sv
hw/rtl/jsu_queue.sv
hw/rtl/jsu_back.sv
hw/rtl/json_string_unescape_utf8_core.sv
dv/testbench.sv
